[sv/cab_pkg.sv]
`default_nettype none

package cab_pkg;

    localparam int IDX_W      = 24;
    localparam int COORD_W    = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 72;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_DEST_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEST_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_X        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POS_Y        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BMP_WIDTH    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BMP_HEIGHT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_GLOBAL_ALPHA = 3'd6;

    localparam logic [12:0]        RST_DEST_WIDTH   = 13'd640;
    localparam logic [12:0]        RST_DEST_HEIGHT  = 13'd480;
    localparam logic signed [13:0] RST_POS_X        = 14'sd0;
    localparam logic signed [13:0] RST_POS_Y        = 14'sd0;
    localparam logic [12:0]        RST_BMP_WIDTH    = 13'd64;
    localparam logic [12:0]        RST_BMP_HEIGHT   = 13'd64;
    localparam logic [8:0]         RST_GLOBAL_ALPHA = 9'd128;
    localparam logic [8:0]         ALPHA_ONE        = 9'd256;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } cab_meta_t;

    typedef struct packed {
        logic [31:0] src;
        logic [23:0] dst;
        cab_meta_t   meta;
    } cab_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cab_queue_status_t;

    // Rounds (d*65280 + prod + 32640) / 65280 down. The sum stays below 2^24,
    // so dividing by 256 and then by 255 with the reciprocal trick is exact.
    function automatic logic [7:0] cab_blend_div(input logic [7:0] d,
                                                 input logic signed [27:0] prod);
        logic [23:0]        d_term;
        logic signed [27:0] n;
        logic [15:0]        m;
        logic [15:0]        t;
        d_term = {d, 16'b0} - {8'b0, d, 8'b0};
        n = $signed({4'b0, d_term}) + prod + 28'sd32640;
        m = n[23:8];
        t = m + {8'b0, m[15:8]} + 16'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

[sv/cab_queue.sv]
`default_nettype none

module cab_queue
    import cab_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_i,
    input  wire cab_item_t         item_i,
    input  wire logic              pop_i,
    output cab_item_t              item_o,
    output cab_queue_status_t      status_o
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cab_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign status_o.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status_o.empty = (count_reg == '0);
    assign do_push = push_i && !status_o.full;
    assign do_pop  = pop_i && !status_o.empty;
    assign item_o  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= item_i;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> !status_o.full)
        else $error("Push into a full queue.");

endmodule

`default_nettype wire

[sv/cab_front.sv]
`default_nettype none

module cab_front
    import cab_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_W-1:0]    s_tdata,
    input  wire cab_queue_status_t      status_i,
    output logic                        push_o,
    output cab_item_t                   item_o,
    output logic [8:0]                  ga_o
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SW    = ((DIM_W > 14) ? DIM_W : 14) + 2;

    localparam logic [1:0] ST_CLIP = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_BASE = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0]          state_reg;
    logic [12:0]         dest_width_reg;
    logic [12:0]         dest_height_reg;
    logic signed [13:0]  pos_x_reg;
    logic signed [13:0]  pos_y_reg;
    logic [12:0]         bmp_width_reg;
    logic [12:0]         bmp_height_reg;
    logic [8:0]          global_alpha_reg;

    logic [DIM_W-1:0]    dw_sat, dh_sat, bw_sat, bh_sat;
    logic signed [SW-1:0] px, py, dws, dhs, bws, bhs;
    logic signed [SW-1:0] x1s, y1s, x0c, y0c, x1c, y1c, dxs, rows_s;
    logic                win_valid_next;

    logic [DIM_W-1:0]    x0_reg, x1_reg, y0_reg, y1_reg;
    logic [DIM_W-1:0]    dx0_reg, rows_reg;
    logic                win_valid_reg;
    logic [DIM_W-1:0]    cur_x_reg, cur_y_reg;
    logic [DIM_W-1:0]    x_inc, y_inc, x_off;
    logic [2*DIM_W-1:0]  prod_full;
    logic [IDX_W-1:0]    prod_reg;
    logic [IDX_W-1:0]    base0_next;
    logic [IDX_W-1:0]    base0_reg;
    logic [IDX_W-1:0]    row_base_reg;

    always_comb begin
        dw_sat = (32'(dest_width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dest_width_reg);
        dh_sat = (32'(dest_height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(dest_height_reg);
        bw_sat = (32'(bmp_width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(bmp_width_reg);
        bh_sat = (32'(bmp_height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(bmp_height_reg);
        ga_o   = (global_alpha_reg > ALPHA_ONE) ? ALPHA_ONE : global_alpha_reg;
    end

    always_comb begin
        px  = SW'(pos_x_reg);
        py  = SW'(pos_y_reg);
        dws = $signed(SW'(dw_sat));
        dhs = $signed(SW'(dh_sat));
        bws = $signed(SW'(bw_sat));
        bhs = $signed(SW'(bh_sat));
        x1s = px + bws;
        y1s = py + bhs;
        x0c = (px < 0) ? '0 : px;
        y0c = (py < 0) ? '0 : py;
        x1c = (x1s > dws) ? dws : x1s;
        y1c = (y1s > dhs) ? dhs : y1s;
        win_valid_next = (x0c < x1c) && (y0c < y1c);
        dxs    = x0c - px;
        rows_s = bhs - y0c + py - SW'(1);
    end

    assign prod_full  = (2*DIM_W)'(bw_sat) * (2*DIM_W)'(rows_reg);
    assign base0_next = prod_reg + IDX_W'(dx0_reg);
    assign x_inc      = cur_x_reg + 1'b1;
    assign y_inc      = cur_y_reg + 1'b1;
    assign x_off      = cur_x_reg - x0_reg;

    assign s_tready = (state_reg == ST_RUN) && (!win_valid_reg || !status_i.full);
    assign push_o   = s_tvalid && s_tready && win_valid_reg;

    always_comb begin
        item_o.src       = s_tdata[31:0];
        item_o.dst       = s_tdata[55:32];
        item_o.meta.x    = COORD_W'(cur_x_reg);
        item_o.meta.y    = COORD_W'(cur_y_reg);
        item_o.meta.idx  = row_base_reg + IDX_W'(x_off);
        item_o.meta.last = (x_inc == x1_reg) && (y_inc == y1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_width_reg   <= RST_DEST_WIDTH;
            dest_height_reg  <= RST_DEST_HEIGHT;
            pos_x_reg        <= RST_POS_X;
            pos_y_reg        <= RST_POS_Y;
            bmp_width_reg    <= RST_BMP_WIDTH;
            bmp_height_reg   <= RST_BMP_HEIGHT;
            global_alpha_reg <= RST_GLOBAL_ALPHA;
            state_reg        <= ST_CLIP;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEST_WIDTH:   dest_width_reg   <= cfg_wdata[12:0];
                REG_DEST_HEIGHT:  dest_height_reg  <= cfg_wdata[12:0];
                REG_POS_X:        pos_x_reg        <= $signed(cfg_wdata[13:0]);
                REG_POS_Y:        pos_y_reg        <= $signed(cfg_wdata[13:0]);
                REG_BMP_WIDTH:    bmp_width_reg    <= cfg_wdata[12:0];
                REG_BMP_HEIGHT:   bmp_height_reg   <= cfg_wdata[12:0];
                REG_GLOBAL_ALPHA: global_alpha_reg <= cfg_wdata[8:0];
                default: ;
            endcase
            state_reg <= ST_CLIP;
        end else begin
            case (state_reg)
                ST_CLIP: state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_BASE;
                ST_BASE: state_reg <= ST_RUN;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_CLIP: begin
                x0_reg        <= DIM_W'(x0c);
                x1_reg        <= DIM_W'(x1c);
                y0_reg        <= DIM_W'(y0c);
                y1_reg        <= DIM_W'(y1c);
                dx0_reg       <= DIM_W'(dxs);
                rows_reg      <= DIM_W'(rows_s);
                win_valid_reg <= win_valid_next;
                cur_x_reg     <= DIM_W'(x0c);
                cur_y_reg     <= DIM_W'(y0c);
            end
            ST_MUL: begin
                prod_reg <= IDX_W'(prod_full);
            end
            ST_BASE: begin
                base0_reg    <= base0_next;
                row_base_reg <= base0_next;
            end
            default: begin
                if (push_o) begin
                    if (x_inc == x1_reg) begin
                        cur_x_reg <= x0_reg;
                        if (y_inc == y1_reg) begin
                            cur_y_reg    <= y0_reg;
                            row_base_reg <= base0_reg;
                        end else begin
                            cur_y_reg    <= y_inc;
                            row_base_reg <= row_base_reg - IDX_W'(bw_sat);
                        end
                    end else begin
                        cur_x_reg <= x_inc;
                    end
                end
            end
        endcase
    end

    a_x_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && win_valid_reg |-> (cur_x_reg >= x0_reg) && (cur_x_reg < x1_reg))
        else $error("Scan column left the clipped window.");

    a_y_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && win_valid_reg |-> (cur_y_reg >= y0_reg) && (cur_y_reg < y1_reg))
        else $error("Scan row left the clipped window.");

endmodule

`default_nettype wire

[sv/cab_back.sv]
`default_nettype none

module cab_back
    import cab_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [8:0]           ga_i,
    input  wire cab_item_t            item_i,
    input  wire cab_queue_status_t    status_i,
    output logic                      pop_o,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_DATA_W-1:0]       m_tdata,
    output logic                      m_tlast
);

    logic               adv;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               out_valid_reg;

    logic [16:0]        w_next;
    logic [16:0]        s1_w_reg;
    cab_item_t          s1_item_reg;

    logic signed [27:0] prod_next [3];
    logic signed [27:0] prod_reg  [3];
    logic [23:0]        s2_dst_reg;
    cab_meta_t          s2_meta_reg;

    logic [23:0]        pix_next;
    logic [23:0]        pix_reg;
    cab_meta_t          out_meta_reg;

    assign adv    = !out_valid_reg || m_tready;
    assign pop_o  = adv && !status_i.empty;
    assign w_next = 17'(item_i.src[31:24]) * 17'(ga_i);

    for (genvar c = 0; c < 3; c++) begin : g_lane
        logic signed [9:0] diff;
        assign diff = $signed({2'b0, s1_item_reg.src[8*c +: 8]})
                    - $signed({2'b0, s1_item_reg.dst[8*c +: 8]});
        assign prod_next[c] = 28'($signed({1'b0, s1_w_reg})) * 28'(diff);
        assign pix_next[8*c +: 8] = cab_blend_div(s2_dst_reg[8*c +: 8], prod_reg[c]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= !status_i.empty;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg  <= item_i;
            s1_w_reg     <= w_next;
            prod_reg     <= prod_next;
            s2_dst_reg   <= s1_item_reg.dst;
            s2_meta_reg  <= s1_item_reg.meta;
            pix_reg      <= pix_next;
            out_meta_reg <= s2_meta_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_meta_reg.idx, out_meta_reg.y, out_meta_reg.x, pix_reg};
    assign m_tlast  = out_meta_reg.last;

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && s2_valid_reg |=> m_tvalid)
        else $error("A blended pixel was dropped before the output register.");

endmodule

`default_nettype wire

[sv/clipped_alpha_blit_unit.sv]
`default_nettype none

// Channel  Direction  Handshake                Payload
// s_       in         s_tvalid / s_tready      s_tdata: src_pixel, dst_pixel
// m_       out        m_tvalid / m_tready      m_tdata: blended_pixel, out_x, out_y,
//                                              src_index; m_tlast: last
// cfg_     in         cfg_we                   cfg_addr, cfg_wdata
//
// After reset and after every configuration write the window setup steps through
// clip, multiply and base add with s_tready low.
// Then one transaction is taken per cycle while the queue is not full.
// A four-entry queue lets input run ahead while the output is stalled.
// Items taken while the clipped window is empty give no result.

module clipped_alpha_blit_unit
    import cab_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // src_pixel [31:0], dst_pixel [55:32]
    input  wire logic [S_DATA_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // blended_pixel [23:0], out_x [35:24], out_y [47:36], src_index [71:48]
    output logic [M_DATA_W-1:0]         m_tdata,
    output logic                        m_tlast
);

    cab_queue_status_t  status;
    cab_item_t          push_item;
    cab_item_t          pop_item;
    logic               push;
    logic               pop;
    logic [8:0]         ga;

    cab_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .status_i  (status),
        .push_o    (push),
        .item_o    (push_item),
        .ga_o      (ga)
    );

    cab_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_i   (push),
        .item_i   (push_item),
        .pop_i    (pop),
        .item_o   (pop_item),
        .status_o (status)
    );

    cab_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ga_i     (ga),
        .item_i   (pop_item),
        .status_i (status),
        .pop_o    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cab_pkg::*;

    localparam int DIM_CAP        = 4096;
    localparam int RESULT_GOAL    = 1850;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PRINT_CAP      = 50;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [31:0]            src;
        logic [23:0]            dst;
        logic                   chk;
        logic [23:0]            pix;
    } plan_row_t;

    typedef struct packed {
        logic [23:0]        pix;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } blit_px_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // src_pixel [31:0], dst_pixel [55:32]
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // blended_pixel [23:0], out_x [35:24], out_y [47:36], src_index [71:48]
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    logic                  pin_chk = 1'b0;
    logic [23:0]           pin_pix = '0;
    bit                    quiet = 1'b0;

    logic [12:0]        blit_dw, blit_dh, blit_bw, blit_bh;
    logic signed [13:0] blit_px, blit_py;
    logic [8:0]         blit_ga;
    int                 win_x0, win_x1, win_y0, win_y1, cur_x, cur_y;
    longint             win_base0, row_base;
    bit                 win_valid;

    blit_px_t  pending_px[$];
    plan_row_t plan[$];
    int        err_cnt = 0;
    int        made_cnt = 0;
    int        checked_cnt = 0;
    int        window_ends = 0;
    int        dropped_cnt = 0;
    int        write_cnt = 0;
    int        idle_cycles = 0;

    clipped_alpha_blit_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int clamp_dim(logic [12:0] v);
        return (v > DIM_CAP) ? DIM_CAP : int'(v);
    endfunction

    function automatic void open_window();
        int dw, dh, bw, bh, px, py;
        dw = clamp_dim(blit_dw);
        dh = clamp_dim(blit_dh);
        bw = clamp_dim(blit_bw);
        bh = clamp_dim(blit_bh);
        px = blit_px;
        py = blit_py;
        win_x0 = (px < 0) ? 0 : px;
        win_y0 = (py < 0) ? 0 : py;
        win_x1 = (px + bw > dw) ? dw : px + bw;
        win_y1 = (py + bh > dh) ? dh : py + bh;
        win_valid = (win_x0 < win_x1) && (win_y0 < win_y1);
        win_base0 = win_valid ? longint'(bw) * (bh - 1 - (win_y0 - py)) + (win_x0 - px) : 0;
        cur_x = win_x0;
        cur_y = win_y0;
        row_base = win_base0;
    endfunction

    function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] d, longint w);
        longint n;
        n = longint'(d) * 65280 + w * (longint'(s) - longint'(d)) + 32640;
        if (n < 0) begin
            n = 0;
        end
        n = n / 65280;
        if (n > 255) begin
            n = 255;
        end
        return n[7:0];
    endfunction

    // Blends one pixel at the scan position and moves the scan on; gives no pixel if the window is empty.
    function automatic bit blit_step(logic [31:0] src, logic [23:0] dst, output blit_px_t px);
        longint w, pos;
        int ga;
        px = '0;
        if (!win_valid) begin
            return 1'b0;
        end
        ga = (blit_ga > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(blit_ga);
        w = longint'(src[31:24]) * ga;
        px.pix = {mix_chan(src[23:16], dst[23:16], w), mix_chan(src[15:8], dst[15:8], w),
                  mix_chan(src[7:0], dst[7:0], w)};
        px.x = cur_x[COORD_W-1:0];
        px.y = cur_y[COORD_W-1:0];
        pos = row_base + (cur_x - win_x0);
        px.idx = pos[IDX_W-1:0];
        px.last = (cur_x == win_x1 - 1) && (cur_y == win_y1 - 1);
        cur_x++;
        if (cur_x >= win_x1) begin
            cur_x = win_x0;
            cur_y++;
            row_base -= clamp_dim(blit_bw);
            if (cur_y >= win_y1) begin
                cur_y = win_y0;
                row_base = win_base0;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_err(string what, logic [31:0] got, logic [31:0] want);
        if (err_cnt < PRINT_CAP) begin
            $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        end
        err_cnt++;
    endtask

    always @(posedge aclk) begin : track
        blit_px_t want;
        if (!aresetn) begin
            blit_dw = RST_DEST_WIDTH;
            blit_dh = RST_DEST_HEIGHT;
            blit_px = RST_POS_X;
            blit_py = RST_POS_Y;
            blit_bw = RST_BMP_WIDTH;
            blit_bh = RST_BMP_HEIGHT;
            blit_ga = RST_GLOBAL_ALPHA;
            open_window();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEST_WIDTH:   blit_dw = cfg_wdata[12:0];
                    REG_DEST_HEIGHT:  blit_dh = cfg_wdata[12:0];
                    REG_POS_X:        blit_px = cfg_wdata;
                    REG_POS_Y:        blit_py = cfg_wdata;
                    REG_BMP_WIDTH:    blit_bw = cfg_wdata[12:0];
                    REG_BMP_HEIGHT:   blit_bh = cfg_wdata[12:0];
                    REG_GLOBAL_ALPHA: blit_ga = cfg_wdata[8:0];
                    default: ;
                endcase
                open_window();
                write_cnt++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_px.size() == 0) begin
                    report_err("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = pending_px.pop_front();
                    if (m_tdata[23:0] !== want.pix)
                        report_err("blended pixel", m_tdata[23:0], want.pix);
                    if (m_tdata[35:24] !== want.x)
                        report_err("out_x", m_tdata[35:24], want.x);
                    if (m_tdata[47:36] !== want.y)
                        report_err("out_y", m_tdata[47:36], want.y);
                    if (m_tdata[71:48] !== want.idx)
                        report_err("src_index", m_tdata[71:48], want.idx);
                    if (m_tlast !== want.last)
                        report_err("last", m_tlast, want.last);
                    checked_cnt++;
                    if (want.last) begin
                        window_ends++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (blit_step(s_tdata[31:0], s_tdata[55:32], want)) begin
                    if (pin_chk) begin
                        want.pix = pin_pix;
                    end
                    pending_px.push_back(want);
                    made_cnt++;
                end else begin
                    dropped_cnt++;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending_px.size());
                $display("tb: errors");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 22);
    end

    task automatic push_item(logic [31:0] src, logic [23:0] dst, logic chk, logic [23:0] pix);
        bit took;
        while (!quiet && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dst, src};
        pin_chk <= chk;
        pin_pix <= pix;
        do begin
            @(posedge aclk);
            took = s_tready;
            @(negedge aclk);
        end while (!took);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_px.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_addr <= addr;
        cfg_wdata <= data;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic plan_row_t row_item(logic [31:0] src, logic [23:0] dst);
        return '{kind: ROW_ITEM, src: src, dst: dst, default: '0};
    endfunction

    function automatic plan_row_t row_chk(logic [31:0] src, logic [23:0] dst, logic [23:0] pix);
        return '{kind: ROW_ITEM, src: src, dst: dst, chk: 1'b1, pix: pix, default: '0};
    endfunction

    function automatic plan_row_t row_cfg(logic [CFG_ADDR_W-1:0] addr,
                                          logic [CFG_DATA_W-1:0] data);
        return '{kind: ROW_CFG, addr: addr, wdata: data, default: '0};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim(bit bmp);
        case ($urandom_range(9))
            0: return bmp ? CFG_DATA_W'(DIM_CAP) : '0;
            1: return bmp ? CFG_DATA_W'($urandom_range(4097, 8191)) : CFG_DATA_W'(DIM_CAP);
            2: return CFG_DATA_W'($urandom_range(4097, 8191));
            3: return CFG_DATA_W'($urandom_range(bmp ? 1 : 0, 8191));
            default: return CFG_DATA_W'(bmp ? $urandom_range(1, 12) : $urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_pos();
        int v;
        case ($urandom_range(9))
            0: v = -8192;
            1: v = 8191;
            2: v = $urandom_range(0, 16383);
            default: v = int'($urandom_range(0, 40)) - 12;
        endcase
        return v[CFG_DATA_W-1:0];
    endfunction

    function automatic logic [31:0] pick_src();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0: v[31:24] = 8'h00;
            1: v[31:24] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        int start_made, n;
        bit first;
        logic [CFG_DATA_W-1:0] ga;

        plan = '{
            row_chk(32'h00FF_FFFF, 24'h12_3456, 24'h12_3456),
            row_chk(32'hFFFF_FFFF, 24'h00_0000, 24'h80_8080),
            row_chk(32'hFF00_0000, 24'hFF_FFFF, 24'h80_8080),
            row_chk(32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF),
            row_item(32'h7F3C_5A96, 24'hA5_C3E1),
            row_cfg(REG_GLOBAL_ALPHA, 14'd256),
            row_chk(32'hFFAB_CDEF, 24'h00_0000, 24'hAB_CDEF),
            row_item(32'h8010_2030, 24'h40_5060),
            row_cfg(REG_GLOBAL_ALPHA, 14'd511),
            row_chk(32'hFF0A_0B0C, 24'hFF_FFFF, 24'h0A_0B0C),
            row_item(32'h01FE_01FE, 24'h01_FE01),
            row_cfg(REG_DEST_WIDTH, 14'd0),
            row_item(32'hFFFF_FFFF, 24'hFF_FFFF),
            row_item(32'h0000_0000, 24'h00_0000),
            row_cfg(REG_DEST_WIDTH, 14'd8191),
            row_cfg(REG_DEST_HEIGHT, 14'd8191),
            row_cfg(REG_BMP_WIDTH, 14'd4096),
            row_cfg(REG_BMP_HEIGHT, 14'd8191),
            row_chk(32'h0000_0000, 24'hFF_FFFF, 24'hFF_FFFF),
            row_chk(32'hFFFF_FFFF, 24'h00_0000, 24'hFF_FFFF),
            row_cfg(REG_BMP_WIDTH, 14'd2),
            row_cfg(REG_BMP_HEIGHT, 14'd1),
            row_item(32'hC012_3456, 24'h65_4321),
            row_cfg(REG_UNUSED, 14'd0),
            row_item(32'h40AA_55AA, 24'h55_AA55),
            row_item(32'hFE80_8080, 24'h7F_7F7F),
            row_item(32'h1234_5678, 24'h9A_BCDE),
            row_cfg(REG_POS_X, 14'h3FFF),
            row_cfg(REG_POS_Y, 14'd1),
            row_item(32'hA5A5_A5A5, 24'h5A_5A5A),
            row_item(32'h5A5A_5A5A, 24'hA5_A5A5),
            row_cfg(REG_POS_X, 14'h1FFF),
            row_item(32'hFFFF_FFFF, 24'h00_0000),
            row_cfg(REG_POS_X, 14'd0),
            row_cfg(REG_POS_Y, 14'h2000),
            row_item(32'hFFFF_FFFF, 24'h00_0000)
        };

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                write_reg(plan[i].addr, plan[i].wdata);
            end else begin
                push_item(plan[i].src, plan[i].dst, plan[i].chk, plan[i].pix);
            end
        end

        start_made = made_cnt;
        first = 1'b1;
        while (made_cnt - start_made < RESULT_GOAL) begin
            settle();
            quiet = (made_cnt - start_made >= 700) && (made_cnt - start_made < 1000);
            if (first || $urandom_range(1)) write_reg(REG_DEST_WIDTH, pick_dim(1'b0));
            if (first || $urandom_range(1)) write_reg(REG_DEST_HEIGHT, pick_dim(1'b0));
            if (first || $urandom_range(1)) write_reg(REG_POS_X, pick_pos());
            if (first || $urandom_range(1)) write_reg(REG_POS_Y, pick_pos());
            if (first || $urandom_range(1)) write_reg(REG_BMP_WIDTH, pick_dim(1'b1));
            if (first || $urandom_range(1)) write_reg(REG_BMP_HEIGHT, pick_dim(1'b1));
            if (first || $urandom_range(1)) begin
                case ($urandom_range(9))
                    0: ga = '0;
                    1: ga = CFG_DATA_W'(ALPHA_ONE);
                    2: ga = CFG_DATA_W'($urandom_range(257, 511));
                    default: ga = CFG_DATA_W'($urandom_range(0, 255));
                endcase
                write_reg(REG_GLOBAL_ALPHA, ga);
            end
            if ($urandom_range(9) == 0) begin
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 16383)));
            end
            first = 1'b0;
            n = win_valid ? $urandom_range(10, 80) : 2;
            repeat (n) push_item(pick_src(), 24'($urandom), 1'b0, '0);
        end

        quiet = 1'b0;
        settle();

        $display("run covered %0d checked pixels, %0d completed windows, %0d register writes,",
                 checked_cnt, window_ends, write_cnt);
        $display("and %0d transactions taken while the clipped window was empty", dropped_cnt);
        if (err_cnt == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
